// File: rtl/sbh_pkg.sv
// Shared types and constants for the slab binning histogram.
// No dependencies; imported by every module of the block.
package sbh_pkg;

  // configuration register indexes
  localparam int          CFG_ADDR_W      = 3;
  localparam int          CFG_DATA_W      = 32;
  localparam logic [2:0]  REG_NUM_SLABS   = 3'd0;
  localparam logic [2:0]  REG_SPLIT_DIM   = 3'd1;
  localparam logic [2:0]  REG_RECIP_XX    = 3'd2;
  localparam logic [2:0]  REG_RECIP_YX    = 3'd3;
  localparam logic [2:0]  REG_RECIP_ZX    = 3'd4;
  localparam logic [2:0]  REG_RECIP_YY    = 3'd5;
  localparam logic [2:0]  REG_RECIP_ZY    = 3'd6;

  // field widths
  localparam int          COORD_W         = 32;
  localparam int          RECIP_W         = 32;
  localparam int          PROD_W          = COORD_W + RECIP_W;
  localparam int          NUM_SLABS_W     = 7;
  localparam int          IDX_OUT_W       = 6;
  localparam int          CNT_OUT_W       = 16;
  // Q16.16 times Q4.28 leaves 44 fraction bits
  localparam int          FRAC_W          = 44;

  localparam logic [RECIP_W-1:0] RECIP_ONE = 32'h1000_0000;

  // split selection
  localparam logic        SPLIT_X         = 1'b0;
  localparam logic        SPLIT_Y         = 1'b1;

  // reciprocal box and split selection, as seen by the locate pipeline
  typedef struct packed {
    logic                       split_dim;
    logic signed [RECIP_W-1:0]  recip_xx;
    logic signed [RECIP_W-1:0]  recip_yx;
    logic signed [RECIP_W-1:0]  recip_zx;
    logic signed [RECIP_W-1:0]  recip_yy;
    logic signed [RECIP_W-1:0]  recip_zy;
  } sbh_cfg_t;

  // update request from the locate pipeline to the count memory
  typedef struct packed {
    logic valid;
    logic clear;
  } sbh_req_t;

endpackage

// File: rtl/sbh_locate.sv
// Slab locate pipeline: products, fractional sum, scale by slab count.
// Depends on sbh_pkg.
module sbh_locate
  import sbh_pkg::*;
#(
  parameter int MAX_SLABS = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [COORD_W-1:0]            coord_x_i,
  input  logic signed [COORD_W-1:0]            coord_y_i,
  input  logic signed [COORD_W-1:0]            coord_z_i,
  input  logic                                 clear_i,
  input  sbh_cfg_t                             cfg_i,
  input  logic [$clog2(MAX_SLABS + 1)-1:0]     nslab_i,
  output sbh_req_t                             req_o,
  output logic [$clog2(MAX_SLABS)-1:0]         idx_o
);

  localparam int NumW = $clog2(MAX_SLABS + 1);
  localparam int IdxW = $clog2(MAX_SLABS);
  localparam int ScW  = FRAC_W + NumW;

  // stage valid and clear flags
  logic [3:0] vld_q;
  logic [3:0] clr_q;

  // stage 0: operand pairs picked by split dimension
  logic signed [COORD_W-1:0] c0_q, c1_q, c2_q;
  logic signed [RECIP_W-1:0] r0_q, r1_q, r2_q;
  // stage 1: products, fraction bits only
  logic [FRAC_W-1:0]         p0_q, p1_q, p2_q;
  logic signed [PROD_W-1:0]  p0_full, p1_full, p2_full;
  // stage 2: fractional coordinate
  logic [FRAC_W-1:0]         frac_q;
  // stage 3: slab index
  logic [ScW-1:0]            scaled;
  logic [IdxW-1:0]           idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      clr_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], start_i};
      clr_q <= {clr_q[2:0], clear_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      if (cfg_i.split_dim == SPLIT_X) begin
        c0_q <= coord_x_i;  r0_q <= cfg_i.recip_xx;
        c1_q <= coord_y_i;  r1_q <= cfg_i.recip_yx;
        c2_q <= coord_z_i;  r2_q <= cfg_i.recip_zx;
      end else begin
        c0_q <= coord_y_i;  r0_q <= cfg_i.recip_yy;
        c1_q <= coord_z_i;  r1_q <= cfg_i.recip_zy;
        c2_q <= '0;         r2_q <= '0;
      end
    end
  end

  assign p0_full = c0_q * r0_q;
  assign p1_full = c1_q * r1_q;
  assign p2_full = c2_q * r2_q;

  // integer part of the sum drops out of floor(n*s) mod n, so only the
  // fraction bits are carried
  always_ff @(posedge clk_i) begin
    p0_q   <= p0_full[FRAC_W-1:0];
    p1_q   <= p1_full[FRAC_W-1:0];
    p2_q   <= p2_full[FRAC_W-1:0];
    frac_q <= p0_q + p1_q + p2_q;
  end

  assign scaled = ScW'(frac_q) * ScW'(nslab_i);

  always_ff @(posedge clk_i) begin
    idx_q <= scaled[FRAC_W +: IdxW];
  end

  assign req_o.valid = vld_q[3];
  assign req_o.clear = clr_q[3];
  assign idx_o       = idx_q;

endmodule

// File: rtl/sbh_count.sv
// Slab count memory with read-modify-write, saturating update and
// per-entry valid bits for the clear. Depends on sbh_pkg.
module sbh_count
  import sbh_pkg::*;
#(
  parameter int MAX_SLABS  = 64,
  parameter int COUNT_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sbh_req_t                      req_i,
  input  logic [$clog2(MAX_SLABS)-1:0]  idx_i,
  input  logic                          take_i,
  output logic                          res_valid_o,
  output logic [$clog2(MAX_SLABS)-1:0]  res_idx_o,
  output logic [COUNT_BITS-1:0]         res_count_o
);

  localparam int IdxW = $clog2(MAX_SLABS);

  logic [COUNT_BITS-1:0] mem [MAX_SLABS];
  logic [COUNT_BITS-1:0] rd_q;
  logic [IdxW-1:0]       idx_q;
  logic                  clr_q;
  logic                  pend_q;
  logic [MAX_SLABS-1:0]  ent_vld_q;
  logic [MAX_SLABS-1:0]  ent_vld_d;
  logic [COUNT_BITS-1:0] old_cnt;
  logic [COUNT_BITS-1:0] new_cnt;
  logic                  wr;

  assign wr = pend_q && take_i;

  // read on request, write back once the result is taken; only one
  // transaction is in flight so reads and writes never overlap
  always_ff @(posedge clk_i) begin
    if (req_i.valid) begin
      rd_q  <= mem[idx_i];
      idx_q <= idx_i;
      clr_q <= req_i.clear;
    end
    if (wr) begin
      mem[idx_q] <= new_cnt;
    end
  end

  assign old_cnt = (clr_q || !ent_vld_q[idx_q]) ? '0 : rd_q;
  assign new_cnt = (&old_cnt) ? old_cnt : old_cnt + 1'b1;

  always_comb begin
    ent_vld_d = ent_vld_q;
    if (wr) begin
      if (clr_q) begin
        ent_vld_d = '0;
      end
      ent_vld_d[idx_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= 1'b0;
      ent_vld_q <= '0;
    end else begin
      ent_vld_q <= ent_vld_d;
      if (req_i.valid) begin
        pend_q <= 1'b1;
      end else if (wr) begin
        pend_q <= 1'b0;
      end
    end
  end

  assign res_valid_o = pend_q;
  assign res_idx_o   = idx_q;
  assign res_count_o = new_cnt;

endmodule

// File: rtl/slab_binning_histogram.sv
// Top level of the slab binning histogram: config registers, input and
// output handshakes. Depends on sbh_pkg, sbh_locate, sbh_count.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------------
//  in       | in_valid_i / in_ready_o   | coord_x_i, coord_y_i, coord_z_i,
//           |                           | clear_counts_i
//  out      | out_valid_o / out_ready_i | slab_index_o, slab_count_o
//  cfg      | cfg_we_i (no wait)        | cfg_addr_i, cfg_wdata_i
//
// One transaction is in flight at a time: a new input is accepted only once
// the previous result has been loaded into the output slot. The steps of a
// transaction, in order: input capture, three products, fraction sum, scale
// by slab count, count memory read, then write-back and output load together.
// Reset clears all counts (per-entry valid bits) and loads config defaults.
// The output register holds a result while out_ready_i is low; the next
// input may be accepted meanwhile, and its write-back waits for the slot.
module slab_binning_histogram
  import sbh_pkg::*;
#(
  parameter int MAX_SLABS  = 64,
  parameter int COUNT_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration writes
  input  logic                       cfg_we_i,
  input  logic [CFG_ADDR_W-1:0]      cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata_i,
  // input transactions
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [COORD_W-1:0]  coord_x_i,
  input  logic signed [COORD_W-1:0]  coord_y_i,
  input  logic signed [COORD_W-1:0]  coord_z_i,
  input  logic                       clear_counts_i,
  // result transactions
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [IDX_OUT_W-1:0]       slab_index_o,
  output logic [CNT_OUT_W-1:0]       slab_count_o
);

  localparam int NumW = $clog2(MAX_SLABS + 1);
  localparam int IdxW = $clog2(MAX_SLABS);
  localparam int CmpW = (NumW > NUM_SLABS_W) ? NumW : NUM_SLABS_W;

  // config registers
  logic [NUM_SLABS_W-1:0]     num_slabs_q;
  logic                       split_dim_q;
  logic signed [RECIP_W-1:0]  recip_xx_q, recip_yx_q, recip_zx_q;
  logic signed [RECIP_W-1:0]  recip_yy_q, recip_zy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_slabs_q <= NUM_SLABS_W'(1);
      split_dim_q <= SPLIT_X;
      recip_xx_q  <= RECIP_ONE;
      recip_yx_q  <= '0;
      recip_zx_q  <= '0;
      recip_yy_q  <= RECIP_ONE;
      recip_zy_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_NUM_SLABS: num_slabs_q <= cfg_wdata_i[NUM_SLABS_W-1:0];
        REG_SPLIT_DIM: split_dim_q <= cfg_wdata_i[0];
        REG_RECIP_XX:  recip_xx_q  <= cfg_wdata_i[RECIP_W-1:0];
        REG_RECIP_YX:  recip_yx_q  <= cfg_wdata_i[RECIP_W-1:0];
        REG_RECIP_ZX:  recip_zx_q  <= cfg_wdata_i[RECIP_W-1:0];
        REG_RECIP_YY:  recip_yy_q  <= cfg_wdata_i[RECIP_W-1:0];
        REG_RECIP_ZY:  recip_zy_q  <= cfg_wdata_i[RECIP_W-1:0];
        default: ;
      endcase
    end
  end

  // effective slab count: zero means one, clamp at MAX_SLABS
  logic [CmpW-1:0] num_ext;
  logic [CmpW-1:0] n_full;
  logic [NumW-1:0] nslab;

  assign num_ext = CmpW'(num_slabs_q);

  always_comb begin
    priority if (num_ext == '0) begin
      n_full = CmpW'(1);
    end else if (num_ext > CmpW'(MAX_SLABS)) begin
      n_full = CmpW'(MAX_SLABS);
    end else begin
      n_full = num_ext;
    end
  end

  assign nslab = n_full[NumW-1:0];

  sbh_cfg_t cfg;
  assign cfg.split_dim = split_dim_q;
  assign cfg.recip_xx  = recip_xx_q;
  assign cfg.recip_yx  = recip_yx_q;
  assign cfg.recip_zx  = recip_zx_q;
  assign cfg.recip_yy  = recip_yy_q;
  assign cfg.recip_zy  = recip_zy_q;

  // input side: busy from accept until the result lands in the output slot
  logic busy_q;
  logic in_acc;
  logic out_free;
  logic res_fire;

  assign in_ready_o = !busy_q;
  assign in_acc     = in_valid_i && in_ready_o;

  sbh_req_t        req;
  logic [IdxW-1:0] loc_idx;

  sbh_locate #(
    .MAX_SLABS (MAX_SLABS)
  ) u_locate (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (in_acc),
    .coord_x_i (coord_x_i),
    .coord_y_i (coord_y_i),
    .coord_z_i (coord_z_i),
    .clear_i   (clear_counts_i),
    .cfg_i     (cfg),
    .nslab_i   (nslab),
    .req_o     (req),
    .idx_o     (loc_idx)
  );

  logic                  res_valid;
  logic [IdxW-1:0]       res_idx;
  logic [COUNT_BITS-1:0] res_count;

  sbh_count #(
    .MAX_SLABS  (MAX_SLABS),
    .COUNT_BITS (COUNT_BITS)
  ) u_count (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .idx_i       (loc_idx),
    .take_i      (out_free),
    .res_valid_o (res_valid),
    .res_idx_o   (res_idx),
    .res_count_o (res_count)
  );

  assign out_free = !out_valid_o || out_ready_i;
  assign res_fire = res_valid && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (in_acc) begin
      busy_q <= 1'b1;
    end else if (res_fire) begin
      busy_q <= 1'b0;
    end
  end

  // output slot
  logic                   out_valid_q;
  logic [IDX_OUT_W-1:0]   idx_out_q;
  logic [CNT_OUT_W-1:0]   cnt_out_q;
  logic [IdxW+IDX_OUT_W-1:0]       idx_ext;
  logic [COUNT_BITS+CNT_OUT_W-1:0] cnt_ext;

  assign idx_ext = {{IDX_OUT_W{1'b0}}, res_idx};
  assign cnt_ext = {{CNT_OUT_W{1'b0}}, res_count};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_fire) begin
      idx_out_q <= idx_ext[IDX_OUT_W-1:0];
      cnt_out_q <= cnt_ext[CNT_OUT_W-1:0];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign slab_index_o = idx_out_q;
  assign slab_count_o = cnt_out_q;

endmodule

// File: rtl/sbh_checker.sv
// Port-level checks for slab_binning_histogram, attached by bind.
// Depends on sbh_pkg and the top level's port list.
module sbh_checker
  import sbh_pkg::*;
(
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       clear_counts_i,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [IDX_OUT_W-1:0]       slab_index_o,
  input logic [CNT_OUT_W-1:0]       slab_count_o
);

  logic in_acc;
  logic new_res;
  logic prev_ov_q;
  logic prev_or_q;
  logic pend_q;
  logic clr_q;

  assign in_acc  = in_valid_i && in_ready_o;
  // a fresh result sits in the output slot this cycle
  assign new_res = out_valid_o && (!prev_ov_q || prev_or_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_ov_q <= 1'b0;
      prev_or_q <= 1'b0;
      pend_q    <= 1'b0;
      clr_q     <= 1'b0;
    end else begin
      prev_ov_q <= out_valid_o;
      prev_or_q <= out_ready_i;
      if (in_acc) begin
        pend_q <= 1'b1;
        clr_q  <= clear_counts_i;
      end else if (new_res) begin
        pend_q <= 1'b0;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(slab_index_o) && $stable(slab_count_o))
    else $error("output changed while stalled");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("input taken while a transaction is in flight");

  a_res_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    new_res |-> pend_q)
    else $error("result without an accepted input");

  a_clear_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    new_res && clr_q |-> slab_count_o == CNT_OUT_W'(1))
    else $error("count after clear is not one");

endmodule

bind slab_binning_histogram sbh_checker u_sbh_checker (.*);
